// ===== design/tcsr_pkg.sv =====
// Shared types and constants for the triplet to compressed-row builder.
// Used by tcsr_mod_unit and triplet_to_csr_dedup_modp_unit; depends on nothing.

package tcsr_pkg;

    localparam int DEF_MAX_ENTRIES = 4096;
    localparam int DEF_MAX_ROWS    = 1024;
    localparam int DEF_MAX_COLS    = 1024;

    localparam int ROW_W   = 10;
    localparam int COL_W   = 10;
    localparam int VALUE_W = 32;
    localparam int RIDX_W  = 13;
    localparam int FV_W    = 31;
    localparam int EXT_W   = 11;
    localparam int CNT_W   = 13;

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 96;
    localparam int PADDR_W   = 3;

    localparam logic [30:0] MODULUS_RESET = 31'd42013;

    localparam logic [PADDR_W-1:0] ADDR_MODULUS = 3'd0;
    localparam logic [PADDR_W-1:0] ADDR_VALUES  = 3'd4;

    typedef enum logic [1:0] {
        REQ_ADD        = 2'd0,
        REQ_COMPRESS   = 2'd1,
        REQ_READ_PTR   = 2'd2,
        REQ_READ_ENTRY = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK             = 2'd0,
        ST_FULL           = 2'd1,
        ST_NOT_COMPRESSED = 2'd2,
        ST_RANGE          = 2'd3
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE, S_ADD_MOD, S_ADD_FIN, S_RD_CHK, S_RD_FIN,
        S_CLR_FP, S_HIST_RD, S_HIST_FP, S_HIST_WR, S_PFX_RD, S_PFX_WR,
        S_SCT_RD, S_SCT_FP, S_SCT_WR, S_CLR_LCP,
        S_MRG_ROW, S_MRG_END, S_MRG_EL, S_MRG_LCP, S_MRG_CHK,
        S_MRG_WAITN, S_MRG_WAITD, S_MRG_ADD1, S_MRG_ADD2, S_MRG_CTR,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic               start;
        logic [VALUE_W-1:0] x;
    } t_mod_req;

    typedef struct packed {
        logic            busy;
        logic [FV_W-1:0] residue;
        logic [FV_W-1:0] centered;
    } t_mod_rsp;

endpackage

// ===== design/tcsr_mod_unit.sv =====
// Iterative reducer: signed 32-bit value modulo a 31-bit prime, one quotient bit per cycle.
// Gives the residue in [0, p) and its centered form. Depends on tcsr_pkg.

module tcsr_mod_unit (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  tcsr_pkg::t_mod_req     i_req,
    input  logic [30:0]            i_p,
    output tcsr_pkg::t_mod_rsp     o_rsp
);

    logic        r_busy, n_busy;
    logic [5:0]  r_cnt, n_cnt;
    logic [31:0] r_mag, n_mag;
    logic [31:0] r_rem, n_rem;
    logic        r_neg, n_neg;
    logic [30:0] r_res, n_res;
    logic [30:0] r_ctr, n_ctr;

    always_comb begin
        logic [31:0] t;
        logic [31:0] p32;
        p32    = {1'b0, i_p};
        t      = {r_rem[30:0], r_mag[31]};
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_mag  = r_mag;
        n_rem  = r_rem;
        n_neg  = r_neg;
        n_res  = r_res;
        n_ctr  = r_ctr;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = 6'd0;
            n_neg  = i_req.x[31];
            n_mag  = i_req.x[31] ? (~i_req.x + 32'd1) : i_req.x;
            n_rem  = 32'd0;
        end else if (r_busy) begin
            if (r_cnt < 6'd32) begin
                n_mag = {r_mag[30:0], 1'b0};
                n_rem = (t >= p32) ? (t - p32) : t;
                n_cnt = r_cnt + 6'd1;
            end else if (r_cnt == 6'd32) begin
                n_res = (r_neg && (r_rem != 32'd0)) ? (i_p - r_rem[30:0]) : r_rem[30:0];
                n_cnt = r_cnt + 6'd1;
            end else begin
                n_ctr  = (r_res > (i_p >> 1)) ? (r_res - i_p) : r_res;
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag <= n_mag;
        r_rem <= n_rem;
        r_neg <= n_neg;
        r_res <= n_res;
        r_ctr <= n_ctr;
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.residue  = r_res;
    assign o_rsp.centered = r_ctr;

endmodule

// ===== design/triplet_to_csr_dedup_modp_unit.sv =====
// Top level of the sparse matrix builder over a prime field: triplet store, counting
// sort into compressed rows, duplicate merge. Depends on tcsr_pkg and tcsr_mod_unit.
//
//  channel   | direction | contents
//  ----------+-----------+-------------------------------------------------------
//  s stream  | in        | one request word: add, compress, read pointer, read entry
//  m stream  | out       | one result word per request
//  APB       | in/out    | modulus (0x0) and values_present (0x4) registers
//
// An add waits for the reducer when values are enabled. A compress runs the count,
// prefix, scatter and merge passes; with values enabled every stored value passes
// the reducer again, and a repeated column adds steps for the sum. The input is
// ready only in the idle state; one finished result may wait in the output
// register while the next word is taken. Reset is synchronous; the stores need
// no clearing pass.

module triplet_to_csr_dedup_modp_unit #(
    parameter int MAX_ENTRIES = tcsr_pkg::DEF_MAX_ENTRIES,
    parameter int MAX_ROWS    = tcsr_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS    = tcsr_pkg::DEF_MAX_COLS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // row_index[9:0], col_index[19:10], entry_value[51:20], read_index[64:52]
    input  logic [tcsr_pkg::S_TDATA_W-1:0]  i_s_tdata,
    // req_type[1:0]
    input  logic [1:0]                      i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // zero_dropped[0], rows_used[11:1], cols_used[22:12], entry_count[35:23],
    // row_start[48:36], out_col[58:49], out_value[89:59]
    output logic [tcsr_pkg::M_TDATA_W-1:0]  o_m_tdata,
    // status[1:0]
    output logic [1:0]                      o_m_tuser,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tcsr_pkg::PADDR_W-1:0]    paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    localparam int EW  = $clog2(MAX_ENTRIES);
    localparam int CW  = $clog2(MAX_ENTRIES + 1);
    localparam int RW  = $clog2(MAX_ROWS);
    localparam int RCW = $clog2(MAX_ROWS + 1);
    localparam int CLW = $clog2(MAX_COLS);
    localparam int CCW = $clog2(MAX_COLS + 1);

    typedef struct packed {
        logic [RW-1:0]  row;
        logic [CLW-1:0] col;
        logic [30:0]    val;
    } t_trip;

    typedef struct packed {
        logic [CLW-1:0] col;
        logic [30:0]    val;
    } t_csr;

    // Column workspace entry: neg set means "no position yet in this compress".
    typedef struct packed {
        logic          neg;
        logic [EW-1:0] pos;
    } t_lcp;

    // ---------------------------------------------------------------- registers
    tcsr_pkg::t_state r_state, n_state;
    logic [30:0]      r_mod, n_mod;
    logic             r_vp, n_vp;
    logic [CW-1:0]    r_trip_count, n_trip_count;
    logic [RCW-1:0]   r_row_ext, n_row_ext;
    logic [CCW-1:0]   r_col_ext, n_col_ext;
    logic             r_csr_valid, n_csr_valid;
    logic [CW-1:0]    r_csr_count, n_csr_count;
    logic [RCW-1:0]   r_csr_rows, n_csr_rows;
    logic             r_m_valid, n_m_valid;

    tcsr_pkg::t_req   r_req, n_req;
    logic [9:0]       r_in_row, n_in_row;
    logic [9:0]       r_in_col, n_in_col;
    logic [12:0]      r_ridx, n_ridx;
    logic [30:0]      r_v, n_v;
    logic [1:0]       r_status, n_status;
    logic             r_zdrop, n_zdrop;
    logic [CW-1:0]    r_rstart, n_rstart;
    logic [CLW-1:0]   r_ocol, n_ocol;
    logic [30:0]      r_oval, n_oval;
    logic [CW-1:0]    r_k, n_k;
    logic [RCW-1:0]   r_i, n_i;
    logic [CCW-1:0]   r_c, n_c;
    logic [CW-1:0]    r_sum, n_sum;
    logic [CW-1:0]    r_nz, n_nz;
    logic [CW-1:0]    r_start, n_start;
    logic [CW-1:0]    r_end, n_end;
    logic [CW-1:0]    r_it, n_it;
    logic [EW-1:0]    r_d, n_d;
    logic [RW-1:0]    r_row, n_row;
    logic [CLW-1:0]   r_col, n_col;
    logic [30:0]      r_val, n_val;
    logic [30:0]      r_a, n_a;
    logic [31:0]      r_s, n_s;
    logic [tcsr_pkg::M_TDATA_W-1:0] r_m_tdata, n_m_tdata;
    logic [1:0]       r_m_tuser, n_m_tuser;

    // ---------------------------------------------------------------- memories
    t_trip            trip_mem [MAX_ENTRIES];
    logic             trip_we, trip_re;
    logic [EW-1:0]    trip_wa, trip_ra;
    t_trip            trip_wd, trip_rd;

    logic [CW-1:0]    fp_mem [MAX_ROWS];
    logic             fp_we, fp_re;
    logic [RW-1:0]    fp_wa, fp_ra;
    logic [CW-1:0]    fp_wd, fp_rd;

    logic [CW-1:0]    rp_mem [MAX_ROWS+1];
    logic             rp_we, rp_re;
    logic [RCW-1:0]   rp_wa, rp_ra;
    logic [CW-1:0]    rp_wd, rp_rd;

    t_lcp             lcp_mem [MAX_COLS];
    logic             lcp_we, lcp_re;
    logic [CLW-1:0]   lcp_wa, lcp_ra;
    t_lcp             lcp_wd, lcp_rd;

    t_csr             csr_mem [MAX_ENTRIES];
    logic             csr_we, csr_re;
    logic [EW-1:0]    csr_wa, csr_ra;
    t_csr             csr_wd, csr_rd;

    always_ff @(posedge i_clk) begin
        if (trip_we) trip_mem[trip_wa] <= trip_wd;
        if (trip_re) trip_rd <= trip_mem[trip_ra];
    end

    always_ff @(posedge i_clk) begin
        if (fp_we) fp_mem[fp_wa] <= fp_wd;
        if (fp_re) fp_rd <= fp_mem[fp_ra];
    end

    always_ff @(posedge i_clk) begin
        if (rp_we) rp_mem[rp_wa] <= rp_wd;
        if (rp_re) rp_rd <= rp_mem[rp_ra];
    end

    always_ff @(posedge i_clk) begin
        if (lcp_we) lcp_mem[lcp_wa] <= lcp_wd;
        if (lcp_re) lcp_rd <= lcp_mem[lcp_ra];
    end

    always_ff @(posedge i_clk) begin
        if (csr_we) csr_mem[csr_wa] <= csr_wd;
        if (csr_re) csr_rd <= csr_mem[csr_ra];
    end

    // ---------------------------------------------------------------- reducer
    logic [30:0]        p_eff;
    tcsr_pkg::t_mod_req mod_req;
    tcsr_pkg::t_mod_rsp mod_rsp;

    // A modulus of 0 or 1 behaves as 2.
    assign p_eff = (r_mod < 31'd2) ? 31'd2 : r_mod;

    tcsr_mod_unit u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mod_req),
        .i_p     (p_eff),
        .o_rsp   (mod_rsp)
    );

    // ---------------------------------------------------------------- APB
    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb begin
        case (paddr)
            tcsr_pkg::ADDR_MODULUS: prdata = {1'b0, r_mod};
            tcsr_pkg::ADDR_VALUES:  prdata = {31'd0, r_vp};
            default:                prdata = 32'd0;
        endcase
    end

    // ---------------------------------------------------------------- sequencer
    logic s_acc;
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == tcsr_pkg::S_IDLE);

    always_comb begin
        logic          is_new;
        logic [CW-1:0] cnt_out;
        logic [30:0]   ctr;
        is_new  = lcp_rd.neg || (CW'(lcp_rd.pos) < r_start);
        cnt_out = (r_req == tcsr_pkg::REQ_ADD) ? r_trip_count
                : (r_csr_valid ? r_csr_count : r_trip_count);
        ctr     = (r_s[30:0] > (p_eff >> 1)) ? (r_s[30:0] - p_eff) : r_s[30:0];

        n_state = r_state;  n_mod = r_mod;  n_vp = r_vp;
        n_trip_count = r_trip_count;  n_row_ext = r_row_ext;  n_col_ext = r_col_ext;
        n_csr_valid = r_csr_valid;  n_csr_count = r_csr_count;  n_csr_rows = r_csr_rows;
        n_m_valid = r_m_valid;  n_req = r_req;  n_in_row = r_in_row;  n_in_col = r_in_col;
        n_ridx = r_ridx;  n_v = r_v;  n_status = r_status;  n_zdrop = r_zdrop;
        n_rstart = r_rstart;  n_ocol = r_ocol;  n_oval = r_oval;  n_k = r_k;  n_i = r_i;
        n_c = r_c;  n_sum = r_sum;  n_nz = r_nz;  n_start = r_start;  n_end = r_end;
        n_it = r_it;  n_d = r_d;  n_row = r_row;  n_col = r_col;  n_val = r_val;
        n_a = r_a;  n_s = r_s;  n_m_tdata = r_m_tdata;  n_m_tuser = r_m_tuser;

        trip_we = 1'b0;  trip_re = 1'b0;  trip_wa = r_trip_count[EW-1:0];
        trip_ra = r_k[EW-1:0];
        trip_wd = '{row: RW'(r_in_row), col: CLW'(r_in_col), val: r_v};
        fp_we = 1'b0;  fp_re = 1'b0;  fp_wa = r_i[RW-1:0];  fp_ra = r_i[RW-1:0];
        fp_wd = '0;
        rp_we = 1'b0;  rp_re = 1'b0;  rp_wa = r_i;  rp_ra = r_i;  rp_wd = r_sum;
        lcp_we = 1'b0;  lcp_re = 1'b0;  lcp_wa = r_col;  lcp_ra = csr_rd.col;
        lcp_wd = '{neg: 1'b0, pos: r_nz[EW-1:0]};
        csr_we = 1'b0;  csr_re = 1'b0;  csr_wa = r_nz[EW-1:0];  csr_ra = r_it[EW-1:0];
        csr_wd = '{col: r_col, val: r_val};
        mod_req.start = 1'b0;
        mod_req.x     = i_s_tdata[51:20];

        if (cfg_wr) begin
            if (paddr == tcsr_pkg::ADDR_MODULUS) n_mod = pwdata[30:0];
            if (paddr == tcsr_pkg::ADDR_VALUES)  n_vp  = pwdata[0];
        end

        // The output register drains independently of the sequencer.
        if (r_m_valid && i_m_tready) n_m_valid = 1'b0;

        case (r_state)
            tcsr_pkg::S_IDLE: begin
                if (s_acc) begin
                    n_req    = tcsr_pkg::t_req'(i_s_tuser);
                    n_in_row = i_s_tdata[9:0];
                    n_in_col = i_s_tdata[19:10];
                    n_ridx   = i_s_tdata[64:52];
                    n_v      = 31'd0;
                    n_status = tcsr_pkg::ST_OK;
                    n_zdrop  = 1'b0;
                    n_rstart = '0;
                    n_ocol   = '0;
                    n_oval   = 31'd0;
                    case (tcsr_pkg::t_req'(i_s_tuser))
                        tcsr_pkg::REQ_ADD: begin
                            if (r_vp) begin
                                mod_req.start = 1'b1;
                                n_state = tcsr_pkg::S_ADD_MOD;
                            end else begin
                                n_state = tcsr_pkg::S_ADD_FIN;
                            end
                        end
                        tcsr_pkg::REQ_COMPRESS: begin
                            n_i     = '0;
                            n_state = tcsr_pkg::S_CLR_FP;
                        end
                        default: n_state = tcsr_pkg::S_RD_CHK;
                    endcase
                end
            end

            tcsr_pkg::S_ADD_MOD: begin
                if (!mod_rsp.busy) begin
                    n_v     = mod_rsp.centered;
                    n_state = tcsr_pkg::S_ADD_FIN;
                end
            end

            tcsr_pkg::S_ADD_FIN: begin
                // With values enabled, a zero value is skipped before any range or full check.
                if (r_vp && (r_v == 31'd0)) begin
                    n_zdrop = 1'b1;
                end else if ((32'(r_in_row) >= 32'(MAX_ROWS)) ||
                             (32'(r_in_col) >= 32'(MAX_COLS))) begin
                    n_status = tcsr_pkg::ST_RANGE;
                end else if (32'(r_trip_count) >= 32'(MAX_ENTRIES)) begin
                    n_status = tcsr_pkg::ST_FULL;
                end else begin
                    trip_we      = 1'b1;
                    n_trip_count = r_trip_count + CW'(1);
                    if (RCW'(r_in_row) + RCW'(1) > r_row_ext)
                        n_row_ext = RCW'(r_in_row) + RCW'(1);
                    if (CCW'(r_in_col) + CCW'(1) > r_col_ext)
                        n_col_ext = CCW'(r_in_col) + CCW'(1);
                end
                n_state = tcsr_pkg::S_RESULT;
            end

            tcsr_pkg::S_RD_CHK: begin
                if (!r_csr_valid) begin
                    n_status = tcsr_pkg::ST_NOT_COMPRESSED;
                    n_state  = tcsr_pkg::S_RESULT;
                end else if (r_req == tcsr_pkg::REQ_READ_PTR) begin
                    if (32'(r_ridx) > 32'(r_csr_rows)) begin
                        n_status = tcsr_pkg::ST_RANGE;
                        n_state  = tcsr_pkg::S_RESULT;
                    end else begin
                        rp_re   = 1'b1;
                        rp_ra   = RCW'(r_ridx);
                        n_state = tcsr_pkg::S_RD_FIN;
                    end
                end else begin
                    if (32'(r_ridx) >= 32'(r_csr_count)) begin
                        n_status = tcsr_pkg::ST_RANGE;
                        n_state  = tcsr_pkg::S_RESULT;
                    end else begin
                        csr_re  = 1'b1;
                        csr_ra  = EW'(r_ridx);
                        n_state = tcsr_pkg::S_RD_FIN;
                    end
                end
            end

            tcsr_pkg::S_RD_FIN: begin
                if (r_req == tcsr_pkg::REQ_READ_PTR) begin
                    n_rstart = rp_rd;
                end else begin
                    n_ocol = csr_rd.col;
                    n_oval = csr_rd.val;
                end
                n_state = tcsr_pkg::S_RESULT;
            end

            // Counting sort, first pass: clear the per-row counters.
            tcsr_pkg::S_CLR_FP: begin
                if (r_i == r_row_ext) begin
                    n_k     = '0;
                    n_state = tcsr_pkg::S_HIST_RD;
                end else begin
                    fp_we = 1'b1;
                    n_i   = r_i + RCW'(1);
                end
            end

            tcsr_pkg::S_HIST_RD: begin
                if (r_k == r_trip_count) begin
                    n_i     = '0;
                    n_sum   = '0;
                    n_state = tcsr_pkg::S_PFX_RD;
                end else begin
                    trip_re = 1'b1;
                    n_state = tcsr_pkg::S_HIST_FP;
                end
            end

            tcsr_pkg::S_HIST_FP: begin
                fp_re   = 1'b1;
                fp_ra   = trip_rd.row;
                n_row   = trip_rd.row;
                n_state = tcsr_pkg::S_HIST_WR;
            end

            tcsr_pkg::S_HIST_WR: begin
                fp_we   = 1'b1;
                fp_wa   = r_row;
                fp_wd   = fp_rd + CW'(1);
                n_k     = r_k + CW'(1);
                n_state = tcsr_pkg::S_HIST_RD;
            end

            // Exclusive prefix sum turns counts into row starts and fill positions.
            tcsr_pkg::S_PFX_RD: begin
                if (r_i == r_row_ext) begin
                    rp_we   = 1'b1;
                    n_k     = '0;
                    n_state = tcsr_pkg::S_SCT_RD;
                end else begin
                    fp_re   = 1'b1;
                    n_state = tcsr_pkg::S_PFX_WR;
                end
            end

            tcsr_pkg::S_PFX_WR: begin
                rp_we   = 1'b1;
                fp_we   = 1'b1;
                fp_wd   = r_sum;
                n_sum   = r_sum + fp_rd;
                n_i     = r_i + RCW'(1);
                n_state = tcsr_pkg::S_PFX_RD;
            end

            // Stable scatter of the triplets into row order.
            tcsr_pkg::S_SCT_RD: begin
                if (r_k == r_trip_count) begin
                    n_c     = '0;
                    n_state = tcsr_pkg::S_CLR_LCP;
                end else begin
                    trip_re = 1'b1;
                    n_state = tcsr_pkg::S_SCT_FP;
                end
            end

            tcsr_pkg::S_SCT_FP: begin
                fp_re   = 1'b1;
                fp_ra   = trip_rd.row;
                n_row   = trip_rd.row;
                n_col   = trip_rd.col;
                n_val   = r_vp ? trip_rd.val : 31'd0;
                n_state = tcsr_pkg::S_SCT_WR;
            end

            tcsr_pkg::S_SCT_WR: begin
                csr_we  = 1'b1;
                csr_wa  = fp_rd[EW-1:0];
                fp_we   = 1'b1;
                fp_wa   = r_row;
                fp_wd   = fp_rd + CW'(1);
                n_k     = r_k + CW'(1);
                n_state = tcsr_pkg::S_SCT_RD;
            end

            tcsr_pkg::S_CLR_LCP: begin
                if (r_c == r_col_ext) begin
                    n_i     = '0;
                    n_nz    = '0;
                    n_it    = '0;
                    n_state = tcsr_pkg::S_MRG_ROW;
                end else begin
                    lcp_we = 1'b1;
                    lcp_wa = r_c[CLW-1:0];
                    lcp_wd = '{neg: 1'b1, pos: '0};
                    n_c    = r_c + CCW'(1);
                end
            end

            // Merge pass: compact each row in place, folding repeated columns.
            tcsr_pkg::S_MRG_ROW: begin
                if (r_i == r_row_ext) begin
                    rp_we       = 1'b1;
                    rp_wd       = r_nz;
                    n_csr_count = r_nz;
                    n_csr_rows  = r_row_ext;
                    n_csr_valid = 1'b1;
                    n_state     = tcsr_pkg::S_RESULT;
                end else begin
                    rp_re   = 1'b1;
                    rp_ra   = r_i + RCW'(1);
                    n_start = r_nz;
                    n_state = tcsr_pkg::S_MRG_END;
                end
            end

            tcsr_pkg::S_MRG_END: begin
                n_end   = rp_rd;
                n_state = tcsr_pkg::S_MRG_EL;
            end

            tcsr_pkg::S_MRG_EL: begin
                if (r_it == r_end) begin
                    rp_we   = 1'b1;
                    rp_wd   = r_start;
                    n_i     = r_i + RCW'(1);
                    n_state = tcsr_pkg::S_MRG_ROW;
                end else begin
                    csr_re  = 1'b1;
                    n_state = tcsr_pkg::S_MRG_LCP;
                end
            end

            tcsr_pkg::S_MRG_LCP: begin
                lcp_re = 1'b1;
                n_col  = csr_rd.col;
                n_val  = csr_rd.val;
                if (r_vp) begin
                    mod_req.start = 1'b1;
                    mod_req.x     = {csr_rd.val[30], csr_rd.val};
                end
                n_state = tcsr_pkg::S_MRG_CHK;
            end

            tcsr_pkg::S_MRG_CHK: begin
                n_d = lcp_rd.pos;
                if (is_new) begin
                    if (r_vp) begin
                        n_state = tcsr_pkg::S_MRG_WAITN;
                    end else begin
                        csr_we  = 1'b1;
                        csr_wd  = '{col: r_col, val: 31'd0};
                        lcp_we  = 1'b1;
                        n_nz    = r_nz + CW'(1);
                        n_it    = r_it + CW'(1);
                        n_state = tcsr_pkg::S_MRG_EL;
                    end
                end else if (r_vp) begin
                    csr_re  = 1'b1;
                    csr_ra  = lcp_rd.pos;
                    n_state = tcsr_pkg::S_MRG_WAITD;
                end else begin
                    n_it    = r_it + CW'(1);
                    n_state = tcsr_pkg::S_MRG_EL;
                end
            end

            tcsr_pkg::S_MRG_WAITN: begin
                if (!mod_rsp.busy) begin
                    csr_we  = 1'b1;
                    csr_wd  = '{col: r_col, val: mod_rsp.centered};
                    lcp_we  = 1'b1;
                    n_nz    = r_nz + CW'(1);
                    n_it    = r_it + CW'(1);
                    n_state = tcsr_pkg::S_MRG_EL;
                end
            end

            // The earlier entry was reduced in this pass, so its residue is one add.
            tcsr_pkg::S_MRG_WAITD: begin
                if (!mod_rsp.busy) begin
                    n_a     = csr_rd.val[30] ? (csr_rd.val + p_eff) : csr_rd.val;
                    n_state = tcsr_pkg::S_MRG_ADD1;
                end
            end

            tcsr_pkg::S_MRG_ADD1: begin
                n_s     = {1'b0, r_a} + {1'b0, mod_rsp.residue};
                n_state = tcsr_pkg::S_MRG_ADD2;
            end

            tcsr_pkg::S_MRG_ADD2: begin
                n_s     = (r_s >= {1'b0, p_eff}) ? (r_s - {1'b0, p_eff}) : r_s;
                n_state = tcsr_pkg::S_MRG_CTR;
            end

            tcsr_pkg::S_MRG_CTR: begin
                csr_we  = 1'b1;
                csr_wa  = r_d;
                csr_wd  = '{col: r_col, val: ctr};
                n_it    = r_it + CW'(1);
                n_state = tcsr_pkg::S_MRG_EL;
            end

            tcsr_pkg::S_RESULT: begin
                if (!r_m_valid || i_m_tready) begin
                    n_m_valid = 1'b1;
                    n_m_tuser = r_status;
                    n_m_tdata = {6'd0, r_oval, 10'(r_ocol), 13'(r_rstart), 13'(cnt_out),
                                 11'(r_col_ext), 11'(r_row_ext), r_zdrop};
                    n_state   = tcsr_pkg::S_IDLE;
                end
            end

            default: n_state = tcsr_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= tcsr_pkg::S_IDLE;
            r_mod        <= tcsr_pkg::MODULUS_RESET;
            r_vp         <= 1'b1;
            r_trip_count <= '0;
            r_row_ext    <= '0;
            r_col_ext    <= '0;
            r_csr_valid  <= 1'b0;
            r_csr_count  <= '0;
            r_csr_rows   <= '0;
            r_m_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_mod        <= n_mod;
            r_vp         <= n_vp;
            r_trip_count <= n_trip_count;
            r_row_ext    <= n_row_ext;
            r_col_ext    <= n_col_ext;
            r_csr_valid  <= n_csr_valid;
            r_csr_count  <= n_csr_count;
            r_csr_rows   <= n_csr_rows;
            r_m_valid    <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req     <= n_req;      r_in_row <= n_in_row;  r_in_col <= n_in_col;
        r_ridx    <= n_ridx;     r_v      <= n_v;       r_status <= n_status;
        r_zdrop   <= n_zdrop;    r_rstart <= n_rstart;  r_ocol   <= n_ocol;
        r_oval    <= n_oval;     r_k      <= n_k;       r_i      <= n_i;
        r_c       <= n_c;        r_sum    <= n_sum;     r_nz     <= n_nz;
        r_start   <= n_start;    r_end    <= n_end;     r_it     <= n_it;
        r_d       <= n_d;        r_row    <= n_row;     r_col    <= n_col;
        r_val     <= n_val;      r_a      <= n_a;       r_s      <= n_s;
        r_m_tdata <= n_m_tdata;  r_m_tuser <= n_m_tuser;
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tuser  = r_m_tuser;

    // ---------------------------------------------------------------- checks
    a_mod_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_req.start |-> !mod_rsp.busy)
        else $error("reducer started while busy");

    a_store_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_trip_count) <= 32'(MAX_ENTRIES))
        else $error("triplet count beyond store depth");

    a_merge_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tcsr_pkg::S_MRG_EL) |-> (r_nz <= r_it))
        else $error("merge write position passed read position");

    a_result_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tcsr_pkg::S_RESULT && (!r_m_valid || i_m_tready))
            |=> (o_m_tvalid && r_state == tcsr_pkg::S_IDLE))
        else $error("result not presented after completion");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for triplet_to_csr_dedup_modp_unit: drives request words,
// predicts every result word in a scoreboard class and compares them field by field.
// Depends on tcsr_pkg and the design files of the block.
`timescale 1ns / 100ps

module testbench;

    // One result word, unpacked into its fields.
    typedef struct packed {
        logic [1:0]                 status;
        logic                       zdrop;
        logic [tcsr_pkg::EXT_W-1:0] rows;
        logic [tcsr_pkg::EXT_W-1:0] cols;
        logic [tcsr_pkg::CNT_W-1:0] count;
        logic [tcsr_pkg::CNT_W-1:0] rstart;
        logic [tcsr_pkg::COL_W-1:0] ocol;
        logic [tcsr_pkg::FV_W-1:0]  oval;
    } t_result;

    // Predicts the block from its own copy of the triplet store and the compressed form,
    // and holds the results still owed by the block in arrival order.
    class csr_scoreboard;
        int unsigned modulus;
        bit          vals_on;
        int          trip_r[4096];
        int          trip_c[4096];
        int          trip_v[4096];
        int          trip_n;
        int          row_ext;
        int          col_ext;
        int          rptr[1025];
        int          ccol[4096];
        int          cval[4096];
        int          fill[1024];
        int          lcp[1024];
        int          csr_n;
        int          csr_rows;
        bit          csr_ok;
        t_result     owed[$];
        int          errors;

        function new();
            modulus = 42013;
            vals_on = 1;
            trip_n = 0;
            row_ext = 0;
            col_ext = 0;
            csr_n = 0;
            csr_rows = 0;
            csr_ok = 0;
            errors = 0;
        endfunction

        function longint field_p();
            return (modulus < 2) ? 64'sd2 : longint'(modulus);
        endfunction

        function longint reduce(longint x, longint p);
            longint r;
            r = x % p;
            if (r < 0) r += p;
            return r;
        endfunction

        // Residues above half the prime map to the negative side.
        function int centered(longint r, longint p);
            if (r > p / 2) r -= p;
            return int'(r);
        endfunction

        // Stable counting sort by row, then merge of repeated columns within each row.
        function void compress();
            longint p;
            int     n;
            int     sum;
            int     c;
            int     nz;
            int     start;
            int     pos;
            p = field_p();
            n = row_ext;
            nz = 0;
            for (int i = 0; i < 1024; i++) fill[i] = 0;
            for (int k = 0; k < trip_n; k++) fill[trip_r[k]]++;
            sum = 0;
            for (int i = 0; i < n; i++) begin
                rptr[i] = sum;
                c = fill[i];
                fill[i] = sum;
                sum += c;
            end
            rptr[n] = sum;
            for (int k = 0; k < trip_n; k++) begin
                pos = fill[trip_r[k]];
                fill[trip_r[k]]++;
                ccol[pos] = trip_c[k];
                cval[pos] = vals_on ? trip_v[k] : 0;
            end
            for (int i = 0; i < col_ext; i++) lcp[i] = -1;
            for (int i = 0; i < n; i++) begin
                start = nz;
                for (int it = rptr[i]; it < rptr[i+1]; it++) begin
                    c = ccol[it];
                    if (lcp[c] < start) begin
                        lcp[c] = nz;
                        ccol[nz] = c;
                        cval[nz] = vals_on ? centered(reduce(cval[it], p), p) : 0;
                        nz++;
                    end else if (vals_on) begin
                        // Duplicates add up in the field; a zero sum stays stored.
                        cval[lcp[c]] = centered(reduce(reduce(cval[lcp[c]], p)
                                                + reduce(cval[it], p), p), p);
                    end
                end
                rptr[i] = start;
            end
            rptr[n] = nz;
            csr_n = nz;
            csr_rows = n;
            csr_ok = 1;
        endfunction

        function void note_request(tcsr_pkg::t_req req, int row, int col, logic [31:0] raw,
                                   int ridx);
            t_result e;
            int      v;
            bit      zero;
            longint  p;
            e = '0;
            if (req == tcsr_pkg::REQ_ADD) begin
                v = 0;
                zero = 0;
                if (vals_on) begin
                    p = field_p();
                    v = centered(reduce(longint'($signed(raw)), p), p);
                    zero = (v == 0);
                end
                if (zero) begin
                    e.zdrop = 1;
                end else if (row >= 1024 || col >= 1024) begin
                    e.status = tcsr_pkg::ST_RANGE;
                end else if (trip_n >= 4096) begin
                    e.status = tcsr_pkg::ST_FULL;
                end else begin
                    trip_r[trip_n] = row;
                    trip_c[trip_n] = col;
                    trip_v[trip_n] = v;
                    trip_n++;
                    if (row + 1 > row_ext) row_ext = row + 1;
                    if (col + 1 > col_ext) col_ext = col + 1;
                end
                e.count = trip_n;
            end else begin
                if (req == tcsr_pkg::REQ_COMPRESS) begin
                    compress();
                end else if (!csr_ok) begin
                    e.status = tcsr_pkg::ST_NOT_COMPRESSED;
                end else if (req == tcsr_pkg::REQ_READ_PTR) begin
                    if (ridx > csr_rows) e.status = tcsr_pkg::ST_RANGE;
                    else e.rstart = rptr[ridx];
                end else begin
                    if (ridx >= csr_n) begin
                        e.status = tcsr_pkg::ST_RANGE;
                    end else begin
                        e.ocol = ccol[ridx];
                        e.oval = cval[ridx];
                    end
                end
                e.count = csr_ok ? csr_n : trip_n;
            end
            e.rows = row_ext;
            e.cols = col_ext;
            owed.push_back(e);
        endfunction

        function void compare(string name, longint want, longint got);
            if (want != got) begin
                if (errors < 10)
                    $display("%0t: mismatch in %s, expected %0h, got %0h",
                             $realtime, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_result got);
            t_result e;
            if (owed.size() == 0) begin
                if (errors < 10) $display("%0t: result word with nothing owed", $realtime);
                errors++;
                return;
            end
            e = owed.pop_front();
            compare("status", e.status, got.status);
            compare("zero_dropped", e.zdrop, got.zdrop);
            compare("rows_used", e.rows, got.rows);
            compare("cols_used", e.cols, got.cols);
            compare("entry_count", e.count, got.count);
            compare("row_start", e.rstart, got.rstart);
            compare("out_col", e.ocol, got.ocol);
            compare("out_value", e.oval, got.oval);
        endfunction
    endclass

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_s_tvalid;
    logic                           o_s_tready;
    logic [tcsr_pkg::S_TDATA_W-1:0] i_s_tdata;
    logic [1:0]                     i_s_tuser;
    logic                           o_m_tvalid;
    logic                           i_m_tready;
    logic [tcsr_pkg::M_TDATA_W-1:0] o_m_tdata;
    logic [1:0]                     o_m_tuser;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [tcsr_pkg::PADDR_W-1:0]   paddr;
    logic [31:0]                    pwdata;
    logic [31:0]                    prdata;
    logic                           pready;

    csr_scoreboard sb = new();

    // Random idling on both sides is switched off for the closing part of the run.
    bit idle_on = 1;
    // Triggering this starts a long receiver hold-off.
    event hold_go;
    bit   hold_on = 0;

    triplet_to_csr_dedup_modp_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial i_clk = 0;
    always #2 i_clk = ~i_clk;

    // Long hold-off of the receiver, counted here in clock cycles.
    initial begin
        forever begin
            @(hold_go);
            hold_on <= 1;
            repeat (300) @(posedge i_clk);
            hold_on <= 0;
        end
    end

    // Receiver: checks each accepted result word, then decides tready for the next cycle.
    // Stalls come in bursts; a hold-off keeps tready low while it lasts.
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_result({o_m_tuser, o_m_tdata[0], o_m_tdata[11:1], o_m_tdata[22:12],
                             o_m_tdata[35:23], o_m_tdata[48:36], o_m_tdata[58:49],
                             o_m_tdata[89:59]});
        if (hold_on) begin
            i_m_tready <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_m_tready <= 0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 7);
            i_m_tready <= 0;
        end else begin
            i_m_tready <= 1;
        end
    end

    // Offers one request word, with an occasional burst of idle cycles first, and
    // notes it with the scoreboard at the edge where it is taken.
    task automatic send_word(tcsr_pkg::t_req req, int row, int col, logic [31:0] raw,
                             int ridx);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_s_tvalid <= 0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_s_tvalid <= 1;
        i_s_tuser <= req;
        i_s_tdata <= {7'd0, ridx[12:0], raw, col[9:0], row[9:0]};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_request(req, row, col, raw, ridx);
    endtask

    // Lowers valid and waits until every owed result has come back.
    task automatic drain();
        i_s_tvalid <= 0;
        @(posedge i_clk);
        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Register write through the configuration port; only called with the block idle.
    task automatic write_reg(logic [tcsr_pkg::PADDR_W-1:0] addr, logic [31:0] data);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0;
        penable <= 0;
        if (addr == tcsr_pkg::ADDR_MODULUS) sb.modulus = data & 32'h7FFF_FFFF;
        else sb.vals_on = data[0];
    endtask

    // Add values weighted toward the reduction corners: multiples of the prime,
    // the centering boundary and the extremes of a 32-bit signed word.
    function automatic logic [31:0] pick_value();
        longint p;
        p = sb.field_p();
        case ($urandom_range(0, 6))
            0: return $urandom;
            1: return $urandom_range(0, 40) - 20;
            2: return 32'(p * $urandom_range(0, 3));
            3: return 32'(p / 2 + $urandom_range(0, 1));
            4: return 32'(-(p / 2) - $urandom_range(0, 1));
            5: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $urandom_range(1, 1000);
        endcase
    endfunction

    function automatic int pick_pos();
        return ($urandom_range(0, 15) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 7);
    endfunction

    task automatic random_read();
        if ($urandom_range(0, 1)) begin
            send_word(tcsr_pkg::REQ_READ_PTR, $urandom, $urandom, $urandom,
                      ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191)
                                                  : $urandom_range(0, sb.csr_rows + 1));
        end else begin
            send_word(tcsr_pkg::REQ_READ_ENTRY, $urandom, $urandom, $urandom,
                      ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191)
                                                  : $urandom_range(0, sb.csr_n));
        end
    endtask

    int unsigned moduli[12] = '{2, 3, 32'h7FFF_FFFF, 0, 1, 7, 65521, 42013, 1000003, 97,
                                13, 2147483629};

    initial begin
        i_rst_n = 0;
        i_s_tvalid = 0;
        i_s_tdata = '0;
        i_s_tuser = tcsr_pkg::REQ_ADD;
        i_m_tready = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed part under the reset settings: reads before any compress, the
        // centering boundary, zero drops, field extremes and a duplicate pair summing to 0.
        send_word(tcsr_pkg::REQ_READ_PTR, 0, 0, 0, 0);
        send_word(tcsr_pkg::REQ_READ_ENTRY, 0, 0, 0, 0);
        send_word(tcsr_pkg::REQ_ADD, 0, 0, 32'h7FFF_FFFF, 0);
        send_word(tcsr_pkg::REQ_ADD, 0, 0, 32'h8000_0000, 8191);
        send_word(tcsr_pkg::REQ_ADD, 3, 5, 0, 0);
        send_word(tcsr_pkg::REQ_ADD, 3, 5, 42013, 0);
        send_word(tcsr_pkg::REQ_ADD, 2, 1, 21006, 0);
        send_word(tcsr_pkg::REQ_ADD, 2, 2, 21007, 0);
        send_word(tcsr_pkg::REQ_ADD, 1023, 1023, -42013, 0);
        send_word(tcsr_pkg::REQ_ADD, 1023, 0, 5, 0);
        send_word(tcsr_pkg::REQ_ADD, 1023, 0, -5, 0);
        send_word(tcsr_pkg::REQ_ADD, 0, 1023, 1, 0);
        send_word(tcsr_pkg::REQ_COMPRESS, 0, 0, 0, 0);
        send_word(tcsr_pkg::REQ_ADD, 4, 4, 9, 0);
        send_word(tcsr_pkg::REQ_READ_PTR, 0, 0, 0, 0);
        send_word(tcsr_pkg::REQ_READ_PTR, 0, 0, 0, 1024);
        send_word(tcsr_pkg::REQ_READ_PTR, 0, 0, 0, 1025);
        send_word(tcsr_pkg::REQ_READ_ENTRY, 0, 0, 0, 0);
        send_word(tcsr_pkg::REQ_READ_ENTRY, 0, 0, 0, sb.csr_n - 1);
        send_word(tcsr_pkg::REQ_READ_ENTRY, 0, 0, 0, sb.csr_n);
        send_word(tcsr_pkg::REQ_READ_ENTRY, 0, 0, 0, 8191);
        drain();

        // Random phases, each under its own settings; some change the modulus
        // between the adds and the compress so stored values get reduced again.
        for (int ph = 0; ph < 12; ph++) begin
            write_reg(tcsr_pkg::ADDR_MODULUS, moduli[ph]);
            write_reg(tcsr_pkg::ADDR_VALUES, (ph % 4 == 2) ? 0 : 1);
            for (int k = 0; k < 40; k++)
                send_word(tcsr_pkg::REQ_ADD, pick_pos(), pick_pos(), pick_value(), $urandom);
            if (ph % 3 == 1) begin
                drain();
                write_reg(tcsr_pkg::ADDR_MODULUS, moduli[(ph + 5) % 12]);
            end
            send_word(tcsr_pkg::REQ_COMPRESS, $urandom, $urandom, $urandom, $urandom);
            if (ph == 4) -> hold_go;
            for (int k = 0; k < 30; k++) begin
                if ($urandom_range(0, 5) == 0)
                    send_word(tcsr_pkg::REQ_ADD, pick_pos(), pick_pos(), pick_value(),
                              $urandom);
                else
                    random_read();
            end
            drain();
        end

        // A zero value, a multiple of the prime and a plain value under the reset modulus.
        write_reg(tcsr_pkg::ADDR_VALUES, 1);
        write_reg(tcsr_pkg::ADDR_MODULUS, 42013);
        send_word(tcsr_pkg::REQ_ADD, 1, 1, 0, 0);
        send_word(tcsr_pkg::REQ_ADD, 1, 1, 84026, 0);
        send_word(tcsr_pkg::REQ_ADD, 1, 1, 17, 0);

        // Closing part at full rate on both sides.
        idle_on = 0;
        send_word(tcsr_pkg::REQ_COMPRESS, 0, 0, 0, 0);
        for (int k = 0; k < 60; k++) random_read();
        send_word(tcsr_pkg::REQ_READ_PTR, 0, 0, 0, sb.csr_rows);
        send_word(tcsr_pkg::REQ_READ_ENTRY, 0, 0, 0, 4095);
        i_s_tvalid <= 0;

        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (sb.errors == 0 && sb.owed.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog well above the slowest correct run.
    initial begin
        #40_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
